// ----- src/tlptw_pkg.sv -----
// Shared constants and types for the two-level page table walker.
package tlptw_pkg;

	// Physical memory geometry
	localparam int PA_BITS   = 12;
	localparam int MEM_BYTES = 1 << PA_BITS;

	// Field widths fixed by the interface
	localparam int VA_BITS   = 14;
	localparam int FIELD_PA  = 12;
	localparam int WORD_BITS = 32;

	typedef logic [PA_BITS-1:0] paddr_t;

	// Byte write request into the physical memory
	typedef struct packed {
		logic   en;
		paddr_t addr;
		logic [7:0] data;
	} mem_wr_t;

	// Byte read request into the physical memory
	typedef struct packed {
		logic   en;
		paddr_t addr;
	} mem_rd_t;

endpackage

// ----- src/tlptw_mem.sv -----
// Byte-wide physical memory: one write port, one read port, registered read data.
module tlptw_mem
	import tlptw_pkg::*;
(
	input  logic       clk,
	input  mem_wr_t    wr,
	input  mem_rd_t    rd,
	output logic [7:0] rd_data
);

	logic [7:0] mem_q [MEM_BYTES];

	// Write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem_q[rd.addr];
		end
	end

endmodule

// ----- src/tlptw_walk.sv -----
// Walk sequencer: byte loads, up to three dependent big-endian word reads, result register.
module tlptw_walk
	import tlptw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [FIELD_PA-1:0]  table_base,
	// request channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [FIELD_PA-1:0]  load_addr,
	input  logic [7:0]           load_byte,
	input  logic [VA_BITS-1:0]   virtual_addr,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 outer_valid,
	output logic                 inner_valid,
	output logic [FIELD_PA-1:0]  physical_addr,
	output logic [WORD_BITS-1:0] read_word,
	// memory side
	output mem_wr_t              mem_wr,
	output mem_rd_t              mem_rd,
	input  logic [7:0]           mem_rdata
);

	// Sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_CAP  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	// Walk levels
	localparam logic [1:0] LVL_OUTER = 2'd0;
	localparam logic [1:0] LVL_INNER = 2'd1;
	localparam logic [1:0] LVL_DATA  = 2'd2;

	logic [1:0]           state_q;
	logic [1:0]           lvl_q;
	logic [1:0]           issue_q;
	paddr_t               base_q;
	logic [VA_BITS-1:0]   va_q;
	logic [23:0]          shift_q;
	logic                 v1_q;
	logic                 v2_q;
	logic [FIELD_PA-1:0]  pa_q;
	logic [WORD_BITS-1:0] data_q;

	logic                 out_valid_q;
	logic                 outer_valid_q;
	logic                 inner_valid_q;
	logic [FIELD_PA-1:0]  physical_addr_q;
	logic [WORD_BITS-1:0] read_word_q;

	logic                 in_beat;
	logic                 out_free;
	logic [WORD_BITS-1:0] word;
	paddr_t               outer_addr;
	paddr_t               inner_addr;
	logic [FIELD_PA-1:0]  pa_next;

	assign in_ready = (state_q == ST_IDLE);
	assign in_beat  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Loads go straight into memory on the accepted beat
	assign mem_wr.en   = in_beat && !kind;
	assign mem_wr.addr = PA_BITS'(load_addr);
	assign mem_wr.data = load_byte;

	// One byte read per cycle while issuing
	assign mem_rd.en   = (state_q == ST_RD);
	assign mem_rd.addr = base_q + PA_BITS'(issue_q);

	// Assembled word once the last byte lands
	assign word = {shift_q, mem_rdata};

	// Address arithmetic for the next level
	assign outer_addr = PA_BITS'(table_base) + PA_BITS'({virtual_addr[13:10], 2'b00});
	assign inner_addr = PA_BITS'(word[31:20]) + PA_BITS'({va_q[9:6], 2'b00});
	assign pa_next    = FIELD_PA'(PA_BITS'({word[31:26], va_q[5:0]}));

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lvl_q   <= LVL_OUTER;
			issue_q <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat && kind) begin
						state_q <= ST_RD;
						lvl_q   <= LVL_OUTER;
						issue_q <= 2'd0;
					end
				end
				ST_RD: begin
					issue_q <= issue_q + 2'd1;
					if (issue_q == 2'd3) begin
						state_q <= ST_CAP;
					end
				end
				ST_CAP: begin
					issue_q <= 2'd0;
					case (lvl_q)
						LVL_OUTER: begin
							state_q <= word[0] ? ST_RD : ST_DONE;
							lvl_q   <= LVL_INNER;
						end
						LVL_INNER: begin
							state_q <= word[0] ? ST_RD : ST_DONE;
							lvl_q   <= LVL_DATA;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk datapath
	always_ff @(posedge clk) begin
		if (in_beat && kind) begin
			base_q <= outer_addr;
			va_q   <= virtual_addr;
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
			pa_q   <= '0;
			data_q <= '0;
		end
		// byte of the previous issue arrives
		if (state_q == ST_RD && issue_q != 2'd0) begin
			shift_q <= {shift_q[15:0], mem_rdata};
		end
		if (state_q == ST_CAP) begin
			case (lvl_q)
				LVL_OUTER: begin
					if (word[0]) begin
						v1_q   <= 1'b1;
						base_q <= inner_addr;
					end
				end
				LVL_INNER: begin
					if (word[0]) begin
						v2_q   <= 1'b1;
						pa_q   <= pa_next;
						base_q <= PA_BITS'(pa_next);
					end
				end
				default: begin
					data_q <= word;
				end
			endcase
		end
	end

	// Result register, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register, payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			outer_valid_q   <= v1_q;
			inner_valid_q   <= v2_q;
			physical_addr_q <= pa_q;
			read_word_q     <= data_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign outer_valid   = outer_valid_q;
	assign inner_valid   = inner_valid_q;
	assign physical_addr = physical_addr_q;
	assign read_word     = read_word_q;

endmodule

// ----- src/two_level_page_table_walker_core.sv -----
// Top level of the two-level page table walker: config register, walker, byte memory.
//
//  channel | signals                                              | dir
//  --------+------------------------------------------------------+-----
//  cfg     | cfg_valid, cfg_ready, cfg_data[11:0] (table base)    | in
//  in      | in_valid, in_ready, kind, load_addr, load_byte,      | in
//          | virtual_addr                                         |
//  out     | out_valid, out_ready, outer_valid, inner_valid,      | out
//          | physical_addr, read_word                             |
//
// A load beat is written to memory as it is accepted. A translate beat reads one to
// three words and then hands off the result. The single read port of the byte
// memory sets the pace: four byte reads and an assembly step per word.
// Reset clears the sequencer, the result valid and the table base; memory contents
// are undefined until loaded. A stalled result holds the walker in its done state
// while the result register stays occupied.
module two_level_page_table_walker_core
	import tlptw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [FIELD_PA-1:0]  cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [FIELD_PA-1:0]  load_addr,
	input  logic [7:0]           load_byte,
	input  logic [VA_BITS-1:0]   virtual_addr,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 outer_valid,
	output logic                 inner_valid,
	output logic [FIELD_PA-1:0]  physical_addr,
	output logic [WORD_BITS-1:0] read_word
);

	logic [FIELD_PA-1:0] table_base_q;
	mem_wr_t             mem_wr;
	mem_rd_t             mem_rd;
	logic [7:0]          mem_rdata;

	// Table base register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			table_base_q <= cfg_data;
		end
	end

	tlptw_walk u_walk (
		.clk           (clk),
		.arst_n        (arst_n),
		.table_base    (table_base_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.load_addr     (load_addr),
		.load_byte     (load_byte),
		.virtual_addr  (virtual_addr),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.outer_valid   (outer_valid),
		.inner_valid   (inner_valid),
		.physical_addr (physical_addr),
		.read_word     (read_word),
		.mem_wr        (mem_wr),
		.mem_rd        (mem_rd),
		.mem_rdata     (mem_rdata)
	);

	tlptw_mem u_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd      (mem_rd),
		.rd_data (mem_rdata)
	);

endmodule
